// ----- rtl/pidt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller package
// Widths, register indexes and the command types shared by the controller
// state machine and the datapath.
// ----------------------------------------------------------------------------
package pidt_pkg;

  localparam int DATA_WIDTH         = 16;
  localparam int GAIN_FRACTION_BITS = 8;
  localparam int INTEGRAL_WIDTH     = 48;

  localparam int GAIN_WIDTH      = 16;
  localparam int OUT_WIDTH       = 16;
  localparam int LIMIT_WIDTH     = OUT_WIDTH - 1;
  localparam int ELAPSED_WIDTH   = 16;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = GAIN_WIDTH;

  localparam int ERR_WIDTH     = DATA_WIDTH + 1;
  localparam int NUM_WIDTH     = DATA_WIDTH + 2;
  localparam int DIV_STEPS     = NUM_WIDTH;
  localparam int DIV_CNT_WIDTH = $clog2(DIV_STEPS + 1);

  localparam int INT_LO_WIDTH = INTEGRAL_WIDTH / 2;
  localparam int INT_HI_WIDTH = INTEGRAL_WIDTH - INT_LO_WIDTH;

  localparam int MUL_A0 = INT_HI_WIDTH + 1;
  localparam int MUL_A1 = NUM_WIDTH;
  localparam int MUL_A2 = ELAPSED_WIDTH + 1;
  localparam int MUL_A_WIDTH = (MUL_A0 > MUL_A1) ? ((MUL_A0 > MUL_A2) ? MUL_A0 : MUL_A2)
                                                 : ((MUL_A1 > MUL_A2) ? MUL_A1 : MUL_A2);
  localparam int MUL_B_WIDTH = (ERR_WIDTH > GAIN_WIDTH) ? ERR_WIDTH : GAIN_WIDTH;
  localparam int PROD_WIDTH  = MUL_A_WIDTH + MUL_B_WIDTH;
  localparam int ACC_WIDTH   = 64;

  localparam logic signed [INTEGRAL_WIDTH-1:0] IOP_LIMIT =
    {2'b01, {(INTEGRAL_WIDTH - 2){1'b0}}};

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_P   = CFG_INDEX_WIDTH'(0);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_D   = CFG_INDEX_WIDTH'(1);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_I   = CFG_INDEX_WIDTH'(2);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_OUT_LIM  = CFG_INDEX_WIDTH'(3);

  typedef enum logic [2:0] {
    MUL_ERR_ELAPSED,
    MUL_P,
    MUL_D,
    MUL_I_LO,
    MUL_I_HI
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_CLEAR,
    ACC_LOAD,
    ACC_ADD,
    ACC_ADD_HI
  } acc_op_t;

  typedef struct packed {
    logic     start;
    logic     clear;
    logic     div_step;
    mul_sel_t mul_sel;
    logic     integ_update;
    logic     iop_load;
    acc_op_t  acc_op;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [GAIN_WIDTH-1:0]  gain_p;
    logic [GAIN_WIDTH-1:0]  gain_d;
    logic [GAIN_WIDTH-1:0]  gain_i;
    logic [LIMIT_WIDTH-1:0] limit;
  } cfg_t;

endpackage

// ----- rtl/pid_controller_timed.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller with elapsed-time input
// Fixed-point PID update with Q8.8 gains, saturating integral and clamped
// drive output.
// ----------------------------------------------------------------------------
// One request is taken at a time. An update request passes first through the
// bit-serial restoring divider that forms the derivative, whose last step also
// forms error times elapsed in the single shared signed multiplier; then a
// step that updates the integral and forms the proportional product; then
// steps that form the derivative product and the two halves of the integral
// product while the accumulator gathers the terms; a step that adds the last
// half; and a step to clamp and register the result. A clear request zeroes
// the stored error and integral and goes straight to that final step, which
// registers a zero drive. The next request is accepted in the cycle after a
// result is registered, even while that result still waits to be taken; a
// result that cannot be registered because the previous one is still held
// waits in the final step. Configuration writes take effect in the next cycle
// and are meant to be made while the block is idle.
module pid_controller_timed (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   cmd,
  input  logic signed [pidt_pkg::DATA_WIDTH-1:0] demand,
  input  logic signed [pidt_pkg::DATA_WIDTH-1:0] measurement,
  input  logic [pidt_pkg::ELAPSED_WIDTH-1:0]     elapsed_ms,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [pidt_pkg::OUT_WIDTH-1:0]  drive,
  output logic                                   clamped,
  input  logic                                   cfg_write,
  input  logic [pidt_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [pidt_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);
  import pidt_pkg::*;

  cfg_t    cfg;
  dp_cmd_t dpc;

  pidt_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pidt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dpc       (dpc)
  );

  pidt_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .dpc         (dpc),
    .cfg         (cfg),
    .demand      (demand),
    .measurement (measurement),
    .elapsed_ms  (elapsed_ms),
    .drive       (drive),
    .clamped     (clamped)
  );

endmodule

// ----- rtl/pidt_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller configuration registers
// Holds the three gains and the output limit. A zero limit write is ignored.
// ----------------------------------------------------------------------------
module pidt_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [pidt_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [pidt_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  output pidt_pkg::cfg_t                       cfg
);
  import pidt_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p <= '0;
      cfg.gain_d <= '0;
      cfg.gain_i <= '0;
      cfg.limit  <= '1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GAIN_P: cfg.gain_p <= cfg_data[GAIN_WIDTH-1:0];
        REG_GAIN_D: cfg.gain_d <= cfg_data[GAIN_WIDTH-1:0];
        REG_GAIN_I: cfg.gain_i <= cfg_data[GAIN_WIDTH-1:0];
        REG_OUT_LIM: begin
          if (cfg_data[LIMIT_WIDTH-1:0] != '0) begin
            cfg.limit <= cfg_data[LIMIT_WIDTH-1:0];
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/pidt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller sequencer
// Steps the datapath through the divide, the integral update and the
// multiply-accumulate passes, and owns the request handshakes.
// ----------------------------------------------------------------------------
module pidt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              cmd,
  output logic              out_valid,
  input  logic              out_stall,
  output pidt_pkg::dp_cmd_t dpc
);
  import pidt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_INTEG,
    S_PROD_P,
    S_PROD_D,
    S_PROD_ILO,
    S_PROD_IHI,
    S_FINISH
  } state_t;

  state_t                   state;
  logic [DIV_CNT_WIDTH-1:0] div_cnt;
  logic                     accept;
  logic                     out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    dpc = '0;
    dpc.mul_sel = MUL_ERR_ELAPSED;
    dpc.acc_op  = ACC_HOLD;
    case (state)
      S_IDLE: begin
        dpc.start = accept && !cmd;
        dpc.clear = accept && cmd;
        dpc.acc_op = (accept && cmd) ? ACC_CLEAR : ACC_HOLD;
      end
      S_DIV: begin
        dpc.div_step = 1'b1;
        dpc.mul_sel  = MUL_ERR_ELAPSED;
      end
      S_INTEG: begin
        dpc.integ_update = 1'b1;
        dpc.mul_sel      = MUL_P;
      end
      S_PROD_P: begin
        dpc.acc_op   = ACC_LOAD;
        dpc.iop_load = 1'b1;
        dpc.mul_sel  = MUL_D;
      end
      S_PROD_D: begin
        dpc.acc_op  = ACC_ADD;
        dpc.mul_sel = MUL_I_LO;
      end
      S_PROD_ILO: begin
        dpc.acc_op  = ACC_ADD;
        dpc.mul_sel = MUL_I_HI;
      end
      S_PROD_IHI: begin
        dpc.acc_op = ACC_ADD_HI;
      end
      S_FINISH: begin
        dpc.out_load = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          div_cnt <= '0;
          if (accept) begin
            state <= cmd ? S_FINISH : S_DIV;
          end
        end
        S_DIV: begin
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DIV_CNT_WIDTH'(DIV_STEPS - 1)) begin
            state <= S_INTEG;
          end
        end
        S_INTEG:    state <= S_PROD_P;
        S_PROD_P:   state <= S_PROD_D;
        S_PROD_D:   state <= S_PROD_ILO;
        S_PROD_ILO: state <= S_PROD_IHI;
        S_PROD_IHI: state <= S_FINISH;
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/pidt_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller datapath
// Error and derivative registers, a restoring divider, the saturating
// integral, one shared signed multiplier, the accumulator and the clamp.
// ----------------------------------------------------------------------------
module pidt_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  pidt_pkg::dp_cmd_t                      dpc,
  input  pidt_pkg::cfg_t                         cfg,
  input  logic signed [pidt_pkg::DATA_WIDTH-1:0] demand,
  input  logic signed [pidt_pkg::DATA_WIDTH-1:0] measurement,
  input  logic [pidt_pkg::ELAPSED_WIDTH-1:0]     elapsed_ms,
  output logic signed [pidt_pkg::OUT_WIDTH-1:0]  drive,
  output logic                                   clamped
);
  import pidt_pkg::*;

  logic signed [ERR_WIDTH-1:0]      error;
  logic signed [ERR_WIDTH-1:0]      prev_error;
  logic [ELAPSED_WIDTH-1:0]         elapsed;
  logic signed [INTEGRAL_WIDTH-1:0] integral;
  logic signed [INTEGRAL_WIDTH-1:0] iop;
  logic [ELAPSED_WIDTH-1:0]         div_rem;
  logic [NUM_WIDTH-1:0]             div_quo;
  logic                             div_neg;
  logic                             div_zero;
  logic signed [PROD_WIDTH-1:0]     prod;
  logic signed [ACC_WIDTH-1:0]      acc;

  logic signed [ERR_WIDTH-1:0]      err_new;
  logic signed [NUM_WIDTH-1:0]      num;
  logic [ELAPSED_WIDTH:0]           rem_shift;
  logic [ELAPSED_WIDTH:0]           rem_diff;
  logic signed [NUM_WIDTH-1:0]      deriv;
  logic signed [MUL_A_WIDTH-1:0]    mul_a;
  logic signed [MUL_B_WIDTH-1:0]    mul_b;
  logic signed [INTEGRAL_WIDTH:0]   integ_sum;
  logic signed [INTEGRAL_WIDTH-1:0] integ_next;
  logic signed [INTEGRAL_WIDTH-1:0] iop_next;
  logic signed [ACC_WIDTH-1:0]      acc_shift;
  logic signed [ACC_WIDTH-1:0]      lim_pos;
  logic signed [ACC_WIDTH-1:0]      lim_neg;
  logic signed [OUT_WIDTH-1:0]      drive_next;
  logic                             clamped_next;

  assign err_new = ERR_WIDTH'(demand) - ERR_WIDTH'(measurement);
  assign num     = NUM_WIDTH'(prev_error) - NUM_WIDTH'(err_new);

  assign rem_shift = {div_rem, div_quo[NUM_WIDTH-1]};
  assign rem_diff  = rem_shift - {1'b0, elapsed};

  always_comb begin
    if (div_zero) begin
      deriv = '0;
    end else if (div_neg) begin
      deriv = -$signed(div_quo);
    end else begin
      deriv = $signed(div_quo);
    end
  end

  always_comb begin
    case (dpc.mul_sel)
      MUL_ERR_ELAPSED: begin
        mul_a = MUL_A_WIDTH'({1'b0, elapsed});
        mul_b = MUL_B_WIDTH'(error);
      end
      MUL_P: begin
        mul_a = MUL_A_WIDTH'(error);
        mul_b = MUL_B_WIDTH'($signed(cfg.gain_p));
      end
      MUL_D: begin
        mul_a = MUL_A_WIDTH'(deriv);
        mul_b = MUL_B_WIDTH'($signed(cfg.gain_d));
      end
      MUL_I_LO: begin
        mul_a = MUL_A_WIDTH'({1'b0, iop[INT_LO_WIDTH-1:0]});
        mul_b = MUL_B_WIDTH'($signed(cfg.gain_i));
      end
      MUL_I_HI: begin
        mul_a = MUL_A_WIDTH'($signed(iop[INTEGRAL_WIDTH-1:INT_LO_WIDTH]));
        mul_b = MUL_B_WIDTH'($signed(cfg.gain_i));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // The integral sticks at the end of its range instead of wrapping.
  assign integ_sum = (INTEGRAL_WIDTH + 1)'(integral) + (INTEGRAL_WIDTH + 1)'(prod);

  always_comb begin
    if (integ_sum[INTEGRAL_WIDTH] != integ_sum[INTEGRAL_WIDTH-1]) begin
      integ_next = integ_sum[INTEGRAL_WIDTH] ? {1'b1, {(INTEGRAL_WIDTH - 1){1'b0}}}
                                             : {1'b0, {(INTEGRAL_WIDTH - 1){1'b1}}};
    end else begin
      integ_next = integ_sum[INTEGRAL_WIDTH-1:0];
    end
  end

  always_comb begin
    if (integral > IOP_LIMIT) begin
      iop_next = IOP_LIMIT;
    end else if (integral < -IOP_LIMIT) begin
      iop_next = -IOP_LIMIT;
    end else begin
      iop_next = integral;
    end
  end

  assign acc_shift = acc >>> GAIN_FRACTION_BITS;
  assign lim_pos   = ACC_WIDTH'({1'b0, cfg.limit});
  assign lim_neg   = -lim_pos;

  always_comb begin
    if (acc_shift > lim_pos) begin
      drive_next   = lim_pos[OUT_WIDTH-1:0];
      clamped_next = 1'b1;
    end else if (acc_shift < lim_neg) begin
      drive_next   = lim_neg[OUT_WIDTH-1:0];
      clamped_next = 1'b1;
    end else begin
      drive_next   = acc_shift[OUT_WIDTH-1:0];
      clamped_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error <= '0;
      integral   <= '0;
    end else if (dpc.clear) begin
      prev_error <= '0;
      integral   <= '0;
    end else begin
      if (dpc.start) begin
        prev_error <= err_new;
      end
      if (dpc.integ_update) begin
        integral <= integ_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dpc.start) begin
      error    <= err_new;
      elapsed  <= elapsed_ms;
      div_rem  <= '0;
      div_neg  <= num[NUM_WIDTH-1];
      div_quo  <= num[NUM_WIDTH-1] ? NUM_WIDTH'(-num) : NUM_WIDTH'(num);
      div_zero <= (elapsed_ms == '0);
    end else if (dpc.div_step) begin
      div_rem <= rem_diff[ELAPSED_WIDTH] ? rem_shift[ELAPSED_WIDTH-1:0]
                                         : rem_diff[ELAPSED_WIDTH-1:0];
      div_quo <= {div_quo[NUM_WIDTH-2:0], ~rem_diff[ELAPSED_WIDTH]};
    end

    prod <= mul_a * mul_b;

    if (dpc.iop_load) begin
      iop <= iop_next;
    end

    case (dpc.acc_op)
      ACC_CLEAR:  acc <= '0;
      ACC_LOAD:   acc <= ACC_WIDTH'(prod);
      ACC_ADD:    acc <= acc + ACC_WIDTH'(prod);
      ACC_ADD_HI: acc <= acc + (ACC_WIDTH'(prod) <<< INT_LO_WIDTH);
      default:    ;
    endcase

    if (dpc.out_load) begin
      drive   <= drive_next;
      clamped <= clamped_next;
    end
  end

endmodule
